// ----- rtl/dbsb_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dbsb_pkg: shared definitions for the defined-byte shadow bitmap
// Geometry of the bitmap, request action codes, configuration register
// indexes and reset values, and the result bundle of the word unit.
// ---------------------------------------------------------------------------
package dbsb_pkg;

   // Bitmap geometry: one bit per byte of the tracked window.
   localparam int WINDOW_BITS = 16;
   localparam int WORD_BITS   = 32;
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int WORD_IDX_W  = WINDOW_BITS - BIT_IDX_W;
   localparam int NUM_WORDS   = 2 ** WORD_IDX_W;
   localparam int STEP_W      = BIT_IDX_W + 1;
   localparam int COUNT_W     = WINDOW_BITS + 1;

   localparam logic [COUNT_W-1:0] WIN_SIZE = COUNT_W'(2 ** WINDOW_BITS);

   // Field widths of the request and response beats.
   localparam int ACTION_W = 2;
   localparam int ADDR_W   = 16;
   localparam int IP_W     = 32;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 1;

   // Request actions.
   localparam logic [ACTION_W-1:0] ACT_UNDEFINE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DEFINE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CHECK    = 2'd2;

   // Configuration registers.
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_MASK  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_MATCH = 1'd1;

   localparam logic [CSR_W-1:0] CODE_MASK_RESET  = 32'hfff0_0000;
   localparam logic [CSR_W-1:0] CODE_MATCH_RESET = 32'h0040_0000;

   // What the word unit hands back for one bitmap word.
   typedef struct packed {
      logic [WORD_BITS-1:0] wr_data;   // word after set or clear of the span
      logic                 und_any;   // span holds an undefined byte
      logic [BIT_IDX_W-1:0] und_idx;   // lowest undefined byte in the span
      logic [STEP_W-1:0]    step;      // bytes of the range in this word
   } word_result_type;

endpackage

// ----- rtl/defined_byte_shadow_bitmap_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// defined_byte_shadow_bitmap_unit: defined-byte shadow bitmap
// Tracks one defined bit per byte of a 64 KiB window and checks reads.
// ---------------------------------------------------------------------------
// Usage:
//   req_* channel takes one beat per request: action (undefine, define,
//   check), start address, byte count and instruction address. The range
//   wraps at the window end; a count above the window size is clamped.
//   rsp_* channel gives one beat per check: violation, first undefined byte
//   (zero when no violation) and the echoed instruction address. Undefine,
//   define and the unused action code give no beat.
//   csr_* port writes the code region mask and match value at any edge with
//   csr_write high; write them only while the block is idle.
// Timing:
//   One request is handled at a time; req_stall is high while it runs.
//   The single bitmap port is shared: each touched word passes through a
//   read state and a modify state, and a check then passes through the
//   response state. A 1 to 8 byte access touches one or two words. A check
//   ends at the first undefined byte; a check outside the code region or of
//   zero bytes goes straight from idle to the response state.
// Reset:
//   Reset starts a clearing pass that zeroes all 2048 bitmap words (all
//   bytes undefined); req_stall stays high until it finishes.
// Stall:
//   A held response does not block a new request; a check that finishes
//   while rsp_stall holds the previous beat waits until the slot frees.
// ---------------------------------------------------------------------------
module defined_byte_shadow_bitmap_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dbsb_pkg::ACTION_W-1:0]    req_action,
   input  logic [dbsb_pkg::ADDR_W-1:0]      req_start_addr,
   input  logic [dbsb_pkg::COUNT_W-1:0]     req_byte_count,
   input  logic [dbsb_pkg::IP_W-1:0]        req_instr_addr,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_violation,
   output logic [dbsb_pkg::ADDR_W-1:0]      rsp_fault_addr,
   output logic [dbsb_pkg::IP_W-1:0]        rsp_reader_addr,
   // configuration
   input  logic                             csr_write,
   input  logic [dbsb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dbsb_pkg::CSR_W-1:0]       csr_data
);
   import dbsb_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_MOD,
      S_RESP
   } state_type;

   state_type                state_ff, state_in;
   logic [WORD_IDX_W-1:0]    clr_ff, clr_in;
   logic [ACTION_W-1:0]      act_ff, act_in;
   logic [WINDOW_BITS-1:0]   cur_ff, cur_in;
   logic [COUNT_W-1:0]       rem_ff, rem_in;
   logic [IP_W-1:0]          ip_ff, ip_in;
   logic                     viol_ff, viol_in;
   logic [ADDR_W-1:0]        fault_ff, fault_in;
   logic [CSR_W-1:0]         code_mask_ff, code_mask_in;
   logic [CSR_W-1:0]         code_match_ff, code_match_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_viol_ff, rsp_viol_in;
   logic [ADDR_W-1:0]        rsp_fault_ff, rsp_fault_in;
   logic [IP_W-1:0]          rsp_ip_ff, rsp_ip_in;

   logic                     req_take;
   logic                     rsp_free;
   logic [COUNT_W-1:0]       count_sat;
   logic                     in_region;
   logic                     last_word;
   logic                     ram_we;
   logic [WORD_IDX_W-1:0]    ram_addr;
   logic [WORD_BITS-1:0]     ram_wdata;
   logic [WORD_BITS-1:0]     ram_rdata;
   word_result_type          unit_res;

   // -----------------------------------------------------------------------
   // Shared bitmap port and word unit
   // -----------------------------------------------------------------------
   assign ram_we    = (state_ff == S_CLEAR) || ((state_ff == S_MOD) && (act_ff != ACT_CHECK));
   assign ram_addr  = (state_ff == S_CLEAR) ? clr_ff : cur_ff[WINDOW_BITS-1:BIT_IDX_W];
   assign ram_wdata = (state_ff == S_CLEAR) ? '0 : unit_res.wr_data;

   dbsb_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   dbsb_word_unit u_word (
      .rd_data  (ram_rdata),
      .offset   (cur_ff[BIT_IDX_W-1:0]),
      .remain   (rem_ff),
      .set_bits (act_ff == ACT_DEFINE),
      .result   (unit_res)
   );

   // -----------------------------------------------------------------------
   // Request side helpers
   // -----------------------------------------------------------------------
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   // Clamp: bytes past the window revisit the same addresses.
   assign count_sat = (req_byte_count > WIN_SIZE) ? WIN_SIZE : req_byte_count;
   assign in_region = (req_instr_addr & code_mask_ff) == code_match_ff;
   assign last_word = (rem_ff == COUNT_W'(unit_res.step));

   // -----------------------------------------------------------------------
   // Sequencer
   // -----------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      act_in        = act_ff;
      cur_in        = cur_ff;
      rem_in        = rem_ff;
      ip_in         = ip_ff;
      viol_in       = viol_ff;
      fault_in      = fault_ff;
      code_mask_in  = code_mask_ff;
      code_match_in = code_match_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_viol_in   = rsp_viol_ff;
      rsp_fault_in  = rsp_fault_ff;
      rsp_ip_in     = rsp_ip_ff;

      // configuration writes
      if (csr_write) begin
         case (csr_index)
            CSR_CODE_MASK:  code_mask_in  = csr_data;
            CSR_CODE_MATCH: code_match_in = csr_data;
            default: ;
         endcase
      end

      // drop the response beat once taken
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_take) begin
               act_in   = req_action;
               cur_in   = req_start_addr[WINDOW_BITS-1:0];
               rem_in   = count_sat;
               ip_in    = req_instr_addr;
               viol_in  = 1'b0;
               fault_in = '0;
               case (req_action)
                  ACT_UNDEFINE, ACT_DEFINE: begin
                     if (count_sat != '0) begin
                        state_in = S_READ;
                     end
                  end
                  ACT_CHECK: begin
                     // outside the code region or empty: answer at once
                     if (in_region && (count_sat != '0)) begin
                        state_in = S_READ;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_READ: begin
            state_in = S_MOD;
         end

         S_MOD: begin
            cur_in = cur_ff + WINDOW_BITS'(unit_res.step);
            rem_in = rem_ff - COUNT_W'(unit_res.step);
            if ((act_ff == ACT_CHECK) && unit_res.und_any) begin
               viol_in  = 1'b1;
               fault_in = ADDR_W'({cur_ff[WINDOW_BITS-1:BIT_IDX_W], unit_res.und_idx});
               state_in = S_RESP;
            end else if (last_word) begin
               state_in = (act_ff == ACT_CHECK) ? S_RESP : S_IDLE;
            end else begin
               state_in = S_READ;
            end
         end

         S_RESP: begin
            // hold until the output slot frees
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_viol_in  = viol_ff;
               rsp_fault_in = fault_ff;
               rsp_ip_in    = ip_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         code_mask_ff  <= CODE_MASK_RESET;
         code_match_ff <= CODE_MATCH_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         code_mask_ff  <= code_mask_in;
         code_match_ff <= code_match_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      act_ff       <= act_in;
      cur_ff       <= cur_in;
      rem_ff       <= rem_in;
      ip_ff        <= ip_in;
      viol_ff      <= viol_in;
      fault_ff     <= fault_in;
      rsp_viol_ff  <= rsp_viol_in;
      rsp_fault_ff <= rsp_fault_in;
      rsp_ip_ff    <= rsp_ip_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_violation   = rsp_viol_ff;
   assign rsp_fault_addr  = rsp_fault_ff;
   assign rsp_reader_addr = rsp_ip_ff;

   // -----------------------------------------------------------------------
   // Assertions
   // -----------------------------------------------------------------------
   // A word step always consumes bytes and never more than remain.
   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD) |-> (unit_res.step != '0) && (COUNT_W'(unit_res.step) <= rem_ff))
      else $error("word step out of range");

   // A response beat only appears after the response state loaded it.
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response beat without a finished check");

   // No violation means no fault address.
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_viol_ff) |-> (rsp_fault_ff == '0))
      else $error("fault address set without violation");

   // The range being walked never exceeds the window.
   a_rem_window: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_READ) || (state_ff == S_MOD)) |-> (rem_ff <= WIN_SIZE) && (rem_ff != '0))
      else $error("remaining count out of range");

endmodule

// ----- rtl/dbsb_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dbsb_ram: bitmap word store
// Single-port memory, one word per access, registered read data.
// ---------------------------------------------------------------------------
module dbsb_ram (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [dbsb_pkg::WORD_IDX_W-1:0]     addr,
   input  logic [dbsb_pkg::WORD_BITS-1:0]      wr_data,
   output logic [dbsb_pkg::WORD_BITS-1:0]      rd_data
);
   import dbsb_pkg::*;

   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/dbsb_word_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dbsb_word_unit: per-word span logic
// Builds the byte mask of the range inside one bitmap word, applies set or
// clear, and finds the lowest undefined byte of the span.
// ---------------------------------------------------------------------------
module dbsb_word_unit (
   input  logic [dbsb_pkg::WORD_BITS-1:0] rd_data,
   input  logic [dbsb_pkg::BIT_IDX_W-1:0] offset,
   input  logic [dbsb_pkg::COUNT_W-1:0]   remain,
   input  logic                           set_bits,
   output dbsb_pkg::word_result_type      result
);
   import dbsb_pkg::*;

   logic [STEP_W-1:0]    room;
   logic [STEP_W-1:0]    step;
   logic [STEP_W-1:0]    end_pos;
   logic [WORD_BITS-1:0] span_mask;
   logic [WORD_BITS-1:0] undef_bits;
   logic [WORD_BITS-1:0] lowest;
   logic [BIT_IDX_W-1:0] idx;

   assign room      = STEP_W'(WORD_BITS) - {1'b0, offset};
   assign step      = (remain >= COUNT_W'(room)) ? room : remain[STEP_W-1:0];
   assign end_pos   = {1'b0, offset} + step;
   // Shift by the full word width yields zero, so the upper mask is all ones.
   assign span_mask = ({WORD_BITS{1'b1}} << offset) & ~({WORD_BITS{1'b1}} << end_pos);

   assign undef_bits = ~rd_data & span_mask;
   assign lowest     = undef_bits & (~undef_bits + 1'b1);

   // Encode the isolated lowest bit.
   always_comb begin
      logic [BIT_IDX_W-1:0] pos;
      idx = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         pos = BIT_IDX_W'(j);
         for (int k = 0; k < BIT_IDX_W; k++) begin
            idx[k] = idx[k] | (lowest[j] & pos[k]);
         end
      end
   end

   assign result.wr_data = set_bits ? (rd_data | span_mask) : (rd_data & ~span_mask);
   assign result.und_any = |undef_bits;
   assign result.und_idx = idx;
   assign result.step    = step;

endmodule
